>>> src/ansi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ansi_pkg: shared character codes, result kinds and the parser-to-emitter request.
// No dependencies.

package ansi_pkg;

    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] FIN_LO    = 8'h40;
    localparam logic [7:0] FIN_HI    = 8'h7E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int unsigned PADDR_W = 3;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_SINGLE,
        RES_TRIPLE
    } res_kind_t;

    typedef struct packed {
        logic      load;
        res_kind_t kind;
        logic [7:0] data;
    } res_req_t;

endpackage

`default_nettype wire

>>> src/ansi_escape_stripper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ansi_escape_stripper_core: top level of the ANSI escape sequence stripper.
// Depends on ansi_pkg, ansi_cfg_regs, ansi_parser, ansi_emitter.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------
//  input    | in        | in_valid / in_stall  | in_byte, buffer_end
//  output   | out       | out_valid / out_stall| out_byte, run_last
//  config   | in        | APB psel/penable     | expand_backspace @ 0x0
//
// One byte per cycle while the output keeps up; a transferred byte goes from the input
// hold register to the output register. An expanded backspace holds the output register
// for three transfers, so the next emitting byte waits for them plus any output stalls.
// Bytes that emit nothing never wait on the output. Reset clears the parser
// to normal text mode and sets expand_backspace.

module ansi_escape_stripper_core
    import ansi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         in_byte,
    input  wire logic               buffer_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic                    run_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic     expand_backspace;
    logic     out_free;
    res_req_t req;

    ansi_cfg_regs u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .expand_backspace (expand_backspace)
    );

    ansi_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_byte          (in_byte),
        .buffer_end       (buffer_end),
        .in_stall         (in_stall),
        .expand_backspace (expand_backspace),
        .out_free         (out_free),
        .req              (req)
    );

    ansi_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .out_stall (out_stall)
    );

    // input only waits on a busy output register
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    // only the expansion yields non-final results
    a_nonlast_is_bs_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> (out_byte == CH_BS || out_byte == CH_SP))
        else $error("non-final result outside backspace expansion");

    // expansion keeps going after a non-final transfer
    a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last && !out_stall) |=> out_valid)
        else $error("backspace expansion cut short");

endmodule

`default_nettype wire

>>> src/ansi_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ansi_cfg_regs: APB register file holding expand_backspace.
// Depends on ansi_pkg.

module ansi_cfg_regs
    import ansi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output logic                    expand_backspace
);

    logic expand_reg;
    logic expand_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);

    always_comb
    begin
        expand_next = expand_reg;
        if (wr_en)
        begin
            expand_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expand_reg <= 1'b1;
        end
        else
        begin
            expand_reg <= expand_next;
        end
    end

    assign prdata           = (paddr[PADDR_W-1] == 1'b0) ? {31'b0, expand_reg} : 32'b0;
    assign expand_backspace = expand_reg;

endmodule

`default_nettype wire

>>> src/ansi_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ansi_parser: input register, escape-sequence state machine and result decode.
// Depends on ansi_pkg.

module ansi_parser
    import ansi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       buffer_end,
    output logic            in_stall,
    input  wire logic       expand_backspace,
    input  wire logic       out_free,
    output res_req_t        req
);

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_SKIPFIN = 3'd2;
    localparam logic [2:0] MODE_OSC     = 3'd3;
    localparam logic [2:0] MODE_OSC_ESC = 3'd4;
    localparam logic [2:0] MODE_DCS     = 3'd5;
    localparam logic [2:0] MODE_DCS_ESC = 3'd6;

    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       hold_end_reg;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [2:0] mode_dec;
    res_kind_t  kind;
    logic       advance;
    logic       in_xfer;
    logic [7:0] b;

    assign b = hold_byte_reg;

    always_comb
    begin
        mode_dec = mode_reg;
        kind     = RES_NONE;
        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (b == CH_ESC)
                begin
                    mode_dec = MODE_ESC;
                end
                else if (b == CH_BS)
                begin
                    kind = expand_backspace ? RES_TRIPLE : RES_NONE;
                end
                else if (b == CH_TAB || b == CH_LF || b == CH_CR ||
                         (b >= CH_SP && b <= CH_TILDE))
                begin
                    kind = RES_SINGLE;
                end
            end
            MODE_ESC:
            begin
                if (b == CH_RBRACK)
                    mode_dec = MODE_OSC;
                else if (b == CH_P)
                    mode_dec = MODE_DCS;
                else
                    mode_dec = MODE_SKIPFIN;
            end
            MODE_SKIPFIN:
            begin
                if (b >= FIN_LO && b <= FIN_HI)
                    mode_dec = MODE_NORMAL;
            end
            MODE_OSC, MODE_OSC_ESC:
            begin
                if (mode_reg == MODE_OSC_ESC && b == CH_BSLASH)
                    mode_dec = MODE_NORMAL;
                else if (b == CH_BEL)
                    mode_dec = MODE_NORMAL;
                else if (b == CH_ESC)
                    mode_dec = MODE_OSC_ESC;
                else
                    mode_dec = MODE_OSC;
            end
            MODE_DCS, MODE_DCS_ESC:
            begin
                if (mode_reg == MODE_DCS_ESC && b == CH_BSLASH)
                    mode_dec = MODE_NORMAL;
                else if (b == CH_ESC)
                    mode_dec = MODE_DCS_ESC;
                else
                    mode_dec = MODE_DCS;
            end
            default:
            begin
                mode_dec = MODE_NORMAL;
            end
        endcase
        if (hold_end_reg)
        begin
            mode_dec = MODE_NORMAL;
        end
    end

    // bytes that emit nothing move on even while the output is busy
    assign advance  = hold_valid_reg && ((kind == RES_NONE) || out_free);
    assign in_stall = hold_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_xfer)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;
        mode_next = advance ? mode_dec : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            mode_reg       <= MODE_NORMAL;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hold_byte_reg <= in_byte;
            hold_end_reg  <= buffer_end;
        end
    end

    always_comb
    begin
        req.load = advance && (kind != RES_NONE);
        req.kind = kind;
        req.data = b;
    end

endmodule

`default_nettype wire

>>> src/ansi_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ansi_emitter: result register; plays out BS SP BS for an expanded backspace.
// Depends on ansi_pkg.

module ansi_emitter
    import ansi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire res_req_t req,
    output logic          out_free,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          run_last,
    input  wire logic     out_stall
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       out_xfer;

    assign out_xfer = valid_reg && !out_stall;
    assign out_free = !valid_reg || (out_xfer && (rem_reg == 2'd0));

    always_comb
    begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (req.load)
        begin
            valid_next = 1'b1;
            if (req.kind == RES_TRIPLE)
            begin
                byte_next = CH_BS;
                last_next = 1'b0;
                rem_next  = 2'd2;
            end
            else
            begin
                byte_next = req.data;
                last_next = 1'b1;
                rem_next  = 2'd0;
            end
        end
        else if (out_xfer)
        begin
            if (rem_reg == 2'd0)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                byte_next = (rem_reg == 2'd2) ? CH_SP : CH_BS;
                last_next = (rem_reg == 2'd1);
                rem_next  = rem_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = last_reg;

endmodule

`default_nettype wire

>>> tb/tb_ansi_escape_stripper_core.sv
`timescale 1ns / 1ps
// tb_ansi_escape_stripper_core: self-checking bench for the ANSI escape stripper core.
// Depends on ansi_pkg and ansi_escape_stripper_core; drives bytes with bursty gaps,
// stalls the output, predicts cleaned bytes and compares every output transfer.

module tb_ansi_escape_stripper_core;
    import ansi_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_EXPAND_BS = 'h0;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED    = 'h4;

    typedef enum logic [2:0] {
        PM_NORMAL,
        PM_ESC,
        PM_SKIP_FINAL,
        PM_OSC,
        PM_OSC_ESC,
        PM_DCS,
        PM_DCS_ESC
    } parse_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } clean_byte_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [7:0]         in_byte    = 8'h00;
    logic               buffer_end = 1'b0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [7:0]         out_byte;
    logic               run_last;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [31:0]        pwdata     = 32'h0;
    logic [31:0]        prdata;
    logic               pready;

    clean_byte_t pending_clean_bytes[$];
    clean_byte_t head_byte;
    parse_mode_e model_mode   = PM_NORMAL;
    logic        model_expand = 1'b1;

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int burst_left     = 0;
    int burst_max      = 8;
    int gap_max        = 3;
    int stall_pct      = 30;
    int stall_run      = 0;

    ansi_escape_stripper_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .buffer_end (buffer_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic parse_mode_e body_mode(input logic [7:0] b, input logic osc);
        if (osc && b == CH_BEL)
            return PM_NORMAL;
        if (b == CH_ESC)
            return osc ? PM_OSC_ESC : PM_DCS_ESC;
        return osc ? PM_OSC : PM_DCS;
    endfunction

    // Advances the parser copy by one byte and queues the bytes it emits.
    function automatic void strip_byte(input logic [7:0] b, input logic last);
        logic [7:0]  emit [3];
        int          n;
        clean_byte_t res;
        n = 0;
        case (model_mode)
            PM_NORMAL:
                if (b == CH_ESC)
                    model_mode = PM_ESC;
                else if (b == CH_BS)
                begin
                    if (model_expand)
                    begin
                        emit[0] = CH_BS;
                        emit[1] = CH_SP;
                        emit[2] = CH_BS;
                        n = 3;
                    end
                end
                else if (b == CH_TAB || b == CH_LF || b == CH_CR ||
                         (b >= CH_SP && b <= CH_TILDE))
                begin
                    emit[0] = b;
                    n = 1;
                end
            PM_ESC:
                if (b == CH_RBRACK)
                    model_mode = PM_OSC;
                else if (b == CH_P)
                    model_mode = PM_DCS;
                else
                    model_mode = PM_SKIP_FINAL;
            PM_SKIP_FINAL:
                if (b >= FIN_LO && b <= FIN_HI)
                    model_mode = PM_NORMAL;
            PM_OSC:
                model_mode = body_mode(b, 1'b1);
            PM_OSC_ESC:
                model_mode = (b == CH_BSLASH) ? PM_NORMAL : body_mode(b, 1'b1);
            PM_DCS:
                model_mode = body_mode(b, 1'b0);
            PM_DCS_ESC:
                model_mode = (b == CH_BSLASH) ? PM_NORMAL : body_mode(b, 1'b0);
            default:
                model_mode = PM_NORMAL;
        endcase
        if (last)
            model_mode = PM_NORMAL;
        for (int i = 0; i < n; i++)
        begin
            res.data = emit[i];
            res.last = (i == n - 1);
            pending_clean_bytes = {pending_clean_bytes, res};
        end
    endfunction

    // Output stall: random runs of stalled and free cycles.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run <= $urandom_range(1, 6);
        end
        else
            stall_run <= stall_run - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_clean_bytes.size() == 0)
                report_mismatch($sformatf("unexpected output byte %02h", out_byte));
            else
            begin
                head_byte = pending_clean_bytes.pop_front();
                if (out_byte !== head_byte.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, head_byte.data));
                if (run_last !== head_byte.last)
                    report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                              run_last, head_byte.last, head_byte.data));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        in_byte    <= b;
        buffer_end <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        strip_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    // Wait until every predicted byte is out and the core has settled.
    task automatic drain_output();
        in_valid <= 1'b0;
        while (pending_clean_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        logic [31:0] rdata;
        drain_output();
        apb_access(1'b1, addr, value, rdata);
        if (addr == ADDR_EXPAND_BS)
            model_expand = value[0];
        @(posedge clk);
        apb_access(1'b0, ADDR_EXPAND_BS, 32'h0, rdata);
        if (rdata[0] !== model_expand)
            report_mismatch($sformatf("expand_backspace reads %b, want %b",
                                      rdata[0], model_expand));
    endtask

    function automatic logic chunk_cut();
        return ($urandom_range(0, 39) == 0);
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 2) == 0) ? CH_TAB :
                      ($urandom_range(0, 1) == 0) ? CH_LF : CH_CR;
            1: return CH_BS;
            default: return 8'($urandom_range(CH_SP, CH_TILDE));
        endcase
    endfunction

    function automatic logic [7:0] body_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(CH_SP, CH_TILDE));
    endfunction

    // One random unit: mostly well-formed sequences, some noise and broken ones.
    task automatic send_random_unit();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(text_byte(), chunk_cut());
            end
            2, 3:
            begin
                send_byte(CH_ESC, 1'b0);
                send_byte(CH_LBRACK, chunk_cut());
                n = $urandom_range(0, 4);
                repeat (n) send_byte(8'($urandom_range(8'h30, 8'h3F)), chunk_cut());
                send_byte(8'($urandom_range(FIN_LO, FIN_HI)), chunk_cut());
            end
            4:
            begin
                send_byte(CH_ESC, 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_RBRACK || b == CH_P);
                send_byte(b, chunk_cut());
                n = $urandom_range(0, 2);
                repeat (n) send_byte(8'($urandom_range(8'h20, 8'h2F)), chunk_cut());
                send_byte(8'($urandom_range(FIN_LO, FIN_HI)), chunk_cut());
            end
            5:
            begin
                send_byte(CH_ESC, 1'b0);
                send_byte(CH_RBRACK, chunk_cut());
                n = $urandom_range(0, 6);
                repeat (n) send_byte(body_byte(), chunk_cut());
                if ($urandom_range(0, 1) == 0)
                    send_byte(CH_BEL, chunk_cut());
                else
                begin
                    send_byte(CH_ESC, 1'b0);
                    send_byte(CH_BSLASH, chunk_cut());
                end
            end
            6:
            begin
                send_byte(CH_ESC, 1'b0);
                send_byte(CH_P, chunk_cut());
                n = $urandom_range(0, 6);
                repeat (n) send_byte(body_byte(), chunk_cut());
                send_byte(CH_ESC, 1'b0);
                send_byte(CH_BSLASH, chunk_cut());
            end
            7:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), chunk_cut());
            end
            8:
            begin
                send_byte(CH_ESC, chunk_cut());
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom_range(0, 255)), chunk_cut());
            end
            default:
                send_byte(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    task automatic test_plain_bytes();
        send_byte(CH_SP, 1'b0);
        send_byte(CH_TILDE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_BS, 1'b0);
    endtask

    task automatic test_csi_and_other_escapes();
        send_text("\033[m", 1'b0);
        // byte after ESC is skipped even though it is a final byte
        send_text("\033AB", 1'b0);
    endtask

    task automatic test_osc_and_dcs();
        send_text("\033]\007", 1'b0);
        send_text("\033]\033z\007", 1'b0);
        send_text("\033]\033\\", 1'b0);
        // BEL does not end DCS; a second ESC restarts the terminator check
        send_text("\033P\007\033\033\\", 1'b0);
    endtask

    task automatic test_chunk_end();
        send_text("\033[1", 1'b1);
        send_text("k", 1'b0);
        send_byte(CH_ESC, 1'b1);
        send_text("q", 1'b0);
    endtask

    task automatic test_backspace_register();
        write_config(ADDR_EXPAND_BS, 32'h0);
        send_byte(CH_BS, 1'b0);
        write_config(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_byte(CH_BS, 1'b0);
        write_config(ADDR_EXPAND_BS, 32'hFFFF_FFFF);
        send_byte(CH_BS, 1'b1);
    endtask

    task automatic test_random_stream(input int n_bytes, input logic expand,
                                      input int burst, input int gap, input int stall);
        int start;
        write_config(ADDR_EXPAND_BS, {31'h0, expand});
        burst_max = burst;
        gap_max   = gap;
        stall_pct = stall;
        start     = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_unit();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_csi_and_other_escapes();
        test_osc_and_dcs();
        test_chunk_end();
        test_backspace_register();
        test_random_stream(135, 1'b1, 64, 0, 0);
        test_random_stream(135, 1'b0, 4, 8, 60);
        test_random_stream(135, 1'b1, 16, 3, 25);
        drain_output();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> ansi_escape_stripper_core.f
src/ansi_pkg.sv
src/ansi_cfg_regs.sv
src/ansi_parser.sv
src/ansi_emitter.sv
src/ansi_escape_stripper_core.sv
tb/tb_ansi_escape_stripper_core.sv
